@@ rtl/range_letter_set_query_defines.svh @@
// Assertion macros for the range letter-set query block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RANGE_LETTER_SET_QUERY_DEFINES_SVH
`define RANGE_LETTER_SET_QUERY_DEFINES_SVH

// Plain property, checked on every clock edge outside reset.
`define RLSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define RLSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RLSQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/rlsq_pkg.sv @@
// Shared types, field widths and helpers for the range letter-set query block.
// No dependencies.
`default_nettype none

package rlsq_pkg;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;
  localparam int POSN_W   = 11;
  localparam int COUNT_W  = 5;
  localparam int YES_MIN  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_WR,
    S_Q_LO,
    S_Q_HI,
    S_Q_WALK,
    S_Q_DRAIN,
    S_FIN
  } state_e;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < 32; k++) begin
      n = n + {5'd0, v[k]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rlsq_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module rlsq_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/range_letter_set_query.sv @@
// Sequencing: an append writes the new letter, then reads and rewrites each upper level
//   whose block ends at the new letter; a valid query reads its end letters, walks the
//   levels, drains and waits on out_ready_i; an invalid query goes straight to the finish
//   state and a clear stays idle. One transaction at a time, as in_ready_o is high only
//   when idle; a query walks the mask table one level or block per cycle under the sequencer.
// Reset clears the sequencer, string length and output valid; the RAMs need no clearing.
`default_nettype none

`include "range_letter_set_query_defines.svh"

module range_letter_set_query #(
  parameter int MAX_LEN  = 1024,
  parameter int LEVELS   = 11,
  parameter int ALPHABET = 26
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rlsq_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [rlsq_pkg::LETTER_W-1:0]  letter_i,
  input  wire logic [rlsq_pkg::POSN_W-1:0]    left_pos_i,
  input  wire logic [rlsq_pkg::POSN_W-1:0]    right_pos_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                answer_yes_o,
  output logic      [rlsq_pkg::COUNT_W-1:0]   distinct_letters_o,
  output logic                                range_error_o
);

  localparam int POS_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int IW0        = (LEN_W > LEVELS) ? LEN_W : LEVELS;
  localparam int IW         = (IW0 > rlsq_pkg::POSN_W) ? IW0 : rlsq_pkg::POSN_W;
  localparam int MASK_DEPTH = LEVELS * (2 ** POS_W);
  localparam int MASK_AW    = LVL_W + POS_W;
  localparam int LTR_AW     = $clog2(MAX_LEN);

  rlsq_pkg::state_e state_q, state_d;
  logic [LEN_W-1:0]              len_q, len_d;
  logic [LVL_W-1:0]              lvl_q, lvl_d;
  logic [IW-1:0]                 stride_q, stride_d;
  logic [IW-1:0]                 pos_q, pos_d;
  logic [IW-1:0]                 hi_q, hi_d;
  logic [rlsq_pkg::POSN_W-1:0]   cnt_q, cnt_d;
  logic [ALPHABET-1:0]           acc_q, acc_d;
  logic                          pend_q;
  logic                          single_q, single_d;
  logic                          err_q, err_d;
  logic [rlsq_pkg::LETTER_W-1:0] ltr_lo_q, ltr_lo_d;

  logic                          out_valid_q;
  logic                          out_yes_q, out_yes_d;
  logic [rlsq_pkg::COUNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic                          out_err_q, out_err_d;
  logic                          out_load;

  logic                          mask_we, mask_re;
  logic [MASK_AW-1:0]            mask_waddr, mask_raddr;
  logic [ALPHABET-1:0]           mask_wdata, mask_rdata;
  logic                          ltr_we, ltr_re;
  logic [LTR_AW-1:0]             ltr_waddr, ltr_raddr;
  logic [rlsq_pkg::LETTER_W-1:0] ltr_wdata, ltr_rdata;

  rlsq_pkg::cmd_e                cmd;
  logic [ALPHABET-1:0]           onehot;
  logic [IW-1:0]                 left_x, right_x, len_x, app_idx;
  logic                          bad_range;
  logic [5:0]                    distinct;
  logic                          lvl_top;

  rlsq_ram #(
    .WIDTH(ALPHABET),
    .DEPTH(MASK_DEPTH)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (mask_we),
    .waddr_i(mask_waddr),
    .wdata_i(mask_wdata),
    .re_i   (mask_re),
    .raddr_i(mask_raddr),
    .rdata_o(mask_rdata)
  );

  rlsq_ram #(
    .WIDTH(rlsq_pkg::LETTER_W),
    .DEPTH(MAX_LEN)
  ) u_ltr_ram (
    .clk_i  (clk_i),
    .we_i   (ltr_we),
    .waddr_i(ltr_waddr),
    .wdata_i(ltr_wdata),
    .re_i   (ltr_re),
    .raddr_i(ltr_raddr),
    .rdata_o(ltr_rdata)
  );

  assign cmd       = rlsq_pkg::cmd_e'(cmd_i);
  assign onehot    = {{(ALPHABET-1){1'b0}}, 1'b1} << letter_i;
  assign left_x    = IW'(left_pos_i);
  assign right_x   = IW'(right_pos_i);
  assign len_x     = IW'(len_q);
  assign bad_range = (left_x == '0) || (left_x > right_x) || (right_x > len_x);
  assign app_idx   = pos_q - stride_q;
  assign distinct  = rlsq_pkg::popcount32(32'(acc_q));
  assign lvl_top   = (lvl_q == LVL_W'(LEVELS - 1));
  assign in_ready_o = (state_q == rlsq_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    lvl_d      = lvl_q;
    stride_d   = stride_q;
    pos_d      = pos_q;
    hi_d       = hi_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    single_d   = single_q;
    err_d      = err_q;
    ltr_lo_d   = ltr_lo_q;
    mask_we    = 1'b0;
    mask_waddr = '0;
    mask_wdata = '0;
    mask_re    = 1'b0;
    mask_raddr = '0;
    ltr_we     = 1'b0;
    ltr_waddr  = '0;
    ltr_wdata  = '0;
    ltr_re     = 1'b0;
    ltr_raddr  = '0;
    out_load   = 1'b0;
    out_yes_d  = 1'b0;
    out_cnt_d  = '0;
    out_err_d  = 1'b0;

    if (pend_q && (state_q == rlsq_pkg::S_Q_WALK || state_q == rlsq_pkg::S_Q_DRAIN)) begin
      acc_d = acc_q | mask_rdata;
    end

    case (state_q)
      rlsq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            rlsq_pkg::CMD_APPEND: begin
              if ((len_q < LEN_W'(MAX_LEN)) && ({1'b0, letter_i} < 6'(ALPHABET))) begin
                ltr_we     = 1'b1;
                ltr_waddr  = len_q[LTR_AW-1:0];
                ltr_wdata  = letter_i;
                mask_we    = 1'b1;
                mask_waddr = {LVL_W'(0), len_q[POS_W-1:0]};
                mask_wdata = onehot;
                acc_d      = onehot;
                pos_d      = len_x + IW'(1);
                lvl_d      = LVL_W'(1);
                stride_d   = IW'(2);
                len_d      = len_q + LEN_W'(1);
                state_d    = rlsq_pkg::S_APP_RD;
              end
            end
            rlsq_pkg::CMD_QUERY: begin
              if (bad_range) begin
                err_d   = 1'b1;
                state_d = rlsq_pkg::S_FIN;
              end else begin
                err_d    = 1'b0;
                pos_d    = left_x - IW'(1);
                hi_d     = right_x - IW'(1);
                cnt_d    = right_pos_i - left_pos_i + rlsq_pkg::POSN_W'(1);
                single_d = (left_pos_i == right_pos_i);
                lvl_d    = '0;
                stride_d = IW'(1);
                acc_d    = '0;
                state_d  = rlsq_pkg::S_Q_LO;
              end
            end
            rlsq_pkg::CMD_CLEAR: begin
              len_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      rlsq_pkg::S_APP_RD: begin
        if (stride_q <= pos_q) begin
          mask_re    = 1'b1;
          mask_raddr = {lvl_q - LVL_W'(1), app_idx[POS_W-1:0]};
          state_d    = rlsq_pkg::S_APP_WR;
        end else begin
          state_d = rlsq_pkg::S_IDLE;
        end
      end
      rlsq_pkg::S_APP_WR: begin
        mask_we    = 1'b1;
        mask_waddr = {lvl_q, app_idx[POS_W-1:0]};
        mask_wdata = acc_q | mask_rdata;
        acc_d      = acc_q | mask_rdata;
        lvl_d      = lvl_q + LVL_W'(1);
        stride_d   = stride_q << 1;
        state_d    = lvl_top ? rlsq_pkg::S_IDLE : rlsq_pkg::S_APP_RD;
      end
      rlsq_pkg::S_Q_LO: begin
        ltr_re    = 1'b1;
        ltr_raddr = pos_q[LTR_AW-1:0];
        state_d   = rlsq_pkg::S_Q_HI;
      end
      rlsq_pkg::S_Q_HI: begin
        ltr_re    = 1'b1;
        ltr_raddr = hi_q[LTR_AW-1:0];
        ltr_lo_d  = ltr_rdata;
        state_d   = rlsq_pkg::S_Q_WALK;
      end
      rlsq_pkg::S_Q_WALK: begin
        if (!lvl_top) begin
          if (cnt_q[0]) begin
            mask_re    = 1'b1;
            mask_raddr = {lvl_q, pos_q[POS_W-1:0]};
            pos_d      = pos_q + stride_q;
          end
          cnt_d    = cnt_q >> 1;
          lvl_d    = lvl_q + LVL_W'(1);
          stride_d = stride_q << 1;
        end else if (cnt_q != '0) begin
          mask_re    = 1'b1;
          mask_raddr = {lvl_q, pos_q[POS_W-1:0]};
          pos_d      = pos_q + stride_q;
          cnt_d      = cnt_q - rlsq_pkg::POSN_W'(1);
        end else begin
          state_d = rlsq_pkg::S_Q_DRAIN;
        end
      end
      rlsq_pkg::S_Q_DRAIN: begin
        state_d = rlsq_pkg::S_FIN;
      end
      rlsq_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (err_q) begin
            out_err_d = 1'b1;
          end else begin
            out_yes_d = single_q || (ltr_lo_q != ltr_rdata) ||
                        (distinct >= 6'(rlsq_pkg::YES_MIN));
            out_cnt_d = distinct[rlsq_pkg::COUNT_W-1:0];
          end
          state_d = rlsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rlsq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlsq_pkg::S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= mask_re;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    stride_q <= stride_d;
    pos_q    <= pos_d;
    hi_q     <= hi_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    single_q <= single_d;
    err_q    <= err_d;
    ltr_lo_q <= ltr_lo_d;
    if (out_load) begin
      out_yes_q <= out_yes_d;
      out_cnt_q <= out_cnt_d;
      out_err_q <= out_err_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign answer_yes_o       = out_yes_q;
  assign distinct_letters_o = out_cnt_q;
  assign range_error_o      = out_err_q;

  `RLSQ_ASSERT(a_len_bound, len_q <= LEN_W'(MAX_LEN), "string length beyond capacity")
  `RLSQ_ASSERT_IMPL(a_result_src, $rose(out_valid_q), $past(state_q == rlsq_pkg::S_FIN), "result not from finish state")
  `RLSQ_ASSERT_IMPL(a_err_result, out_valid_q && out_err_q, !out_yes_q && (out_cnt_q == '0), "error result carries data")
  `RLSQ_ASSERT_IMPL(a_mask_wr_state, mask_we, (state_q == rlsq_pkg::S_IDLE) || (state_q == rlsq_pkg::S_APP_WR), "mask write outside append")

endmodule

`default_nettype wire

@@ tb/range_letter_set_query_tb.sv @@
// Self-checking testbench for range_letter_set_query: a directed table, then random
// append/query/clear traffic, scored against a behavioral letter-set predictor or a
// row's fixed answer. Depends on rlsq_pkg and the range_letter_set_query RTL.
module range_letter_set_query_tb;

  localparam int MAX_LEN        = 1024;
  localparam int LEVELS         = 11;
  localparam int ALPHABET       = 26;
  localparam int DIRECTED_ROWS  = 25;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * LEVELS;

  localparam logic [rlsq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic                         yes;
    logic [rlsq_pkg::COUNT_W-1:0] letters;
    logic                         err;
  } query_result_t;

  typedef struct packed {
    logic [rlsq_pkg::CMD_W-1:0]    cmd;
    logic [rlsq_pkg::LETTER_W-1:0] letter;
    logic [rlsq_pkg::POSN_W-1:0]   left;
    logic [rlsq_pkg::POSN_W-1:0]   right;
    logic                          typed;
    query_result_t                 want;
  } stim_row_t;

  localparam query_result_t RANGE_FAULT = '{yes: 1'b0, letters: 5'd0, err: 1'b1};
  localparam query_result_t NO_RESULT   = '0;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [rlsq_pkg::CMD_W-1:0]    cmd_i       = '0;
  logic [rlsq_pkg::LETTER_W-1:0] letter_i    = '0;
  logic [rlsq_pkg::POSN_W-1:0]   left_pos_i  = '0;
  logic [rlsq_pkg::POSN_W-1:0]   right_pos_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          answer_yes_o;
  logic [rlsq_pkg::COUNT_W-1:0]  distinct_letters_o;
  logic                          range_error_o;

  logic [rlsq_pkg::LETTER_W-1:0] text_letters [MAX_LEN];
  int unsigned                   text_len = 0;
  query_result_t                 expected_answers [$];
  query_result_t                 oldest_answer;
  int                            error_count = 0;
  int                            items_sent  = 0;
  int                            idle_cycles = 0;
  bit                            steady_flow = 1'b0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd1,    1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_APPEND, 5'd0,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_APPEND, 5'd25, 11'd2047, 11'd2047, 1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_APPEND, 5'd26, 11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_APPEND, 5'd31, 11'd0,    11'd0,    1'b0, NO_RESULT},
    '{CMD_UNUSED,           5'd0,  11'd2047, 11'd2047, 1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd1,    1'b1, '{1'b1, 5'd1, 1'b0}},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd2,    11'd2,    1'b1, '{1'b1, 5'd1, 1'b0}},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd2,    1'b1, '{1'b1, 5'd2, 1'b0}},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd0,    11'd2,    1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd2,    11'd1,    1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd3,    1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_QUERY,  5'd31, 11'd2047, 11'd2047, 1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_APPEND, 5'd0,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd3,    1'b1, '{1'b0, 5'd2, 1'b0}},
    '{rlsq_pkg::CMD_APPEND, 5'd1,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_APPEND, 5'd0,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd5,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd3,    11'd5,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_CLEAR,  5'd31, 11'd2047, 11'd2047, 1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd1,    1'b1, RANGE_FAULT},
    '{rlsq_pkg::CMD_APPEND, 5'd2,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_APPEND, 5'd2,  11'd0,    11'd0,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_QUERY,  5'd0,  11'd1,    11'd2,    1'b0, NO_RESULT},
    '{rlsq_pkg::CMD_CLEAR,  5'd0,  11'd0,    11'd0,    1'b0, NO_RESULT}
  };

  range_letter_set_query #(
    .MAX_LEN (MAX_LEN),
    .LEVELS  (LEVELS),
    .ALPHABET(ALPHABET)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .letter_i          (letter_i),
    .left_pos_i        (left_pos_i),
    .right_pos_i       (right_pos_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .answer_yes_o      (answer_yes_o),
    .distinct_letters_o(distinct_letters_o),
    .range_error_o     (range_error_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void apply_item(input logic [rlsq_pkg::CMD_W-1:0] cmd,
                                     input logic [rlsq_pkg::LETTER_W-1:0] letter,
                                     input logic [rlsq_pkg::POSN_W-1:0] left,
                                     input logic [rlsq_pkg::POSN_W-1:0] right,
                                     output bit has_answer, output query_result_t answer);
    logic [ALPHABET-1:0] seen;
    int unsigned         n;
    has_answer = 1'b0;
    answer     = '0;
    case (cmd)
      rlsq_pkg::CMD_APPEND: begin
        if (text_len < MAX_LEN && letter < ALPHABET) begin
          text_letters[text_len] = letter;
          text_len++;
        end
      end
      rlsq_pkg::CMD_CLEAR: text_len = 0;
      rlsq_pkg::CMD_QUERY: begin
        has_answer = 1'b1;
        if (left == 0 || left > right || right > text_len) begin
          answer = RANGE_FAULT;
        end else begin
          seen = '0;
          for (int k = left - 1; k < right; k++) seen |= ALPHABET'(1) << text_letters[k];
          n = $countones(seen);
          answer.yes = (left == right) || (text_letters[left-1] != text_letters[right-1]) ||
                       (n >= rlsq_pkg::YES_MIN);
          answer.letters = n[rlsq_pkg::COUNT_W-1:0];
          answer.err     = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [rlsq_pkg::POSN_W-1:0] rand_posn();
    return rlsq_pkg::POSN_W'($urandom());
  endfunction

  function automatic logic [rlsq_pkg::LETTER_W-1:0] rand_letter();
    return rlsq_pkg::LETTER_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [rlsq_pkg::POSN_W-1:0] posn(input int unsigned v);
    return rlsq_pkg::POSN_W'(v);
  endfunction

  function automatic logic [rlsq_pkg::LETTER_W-1:0] ltr(input int unsigned v);
    return rlsq_pkg::LETTER_W'(v);
  endfunction

  task automatic send_item(input logic [rlsq_pkg::CMD_W-1:0] cmd,
                           input logic [rlsq_pkg::LETTER_W-1:0] letter,
                           input logic [rlsq_pkg::POSN_W-1:0] left,
                           input logic [rlsq_pkg::POSN_W-1:0] right,
                           input bit typed = 1'b0, input query_result_t want = '0);
    bit            has_answer;
    query_result_t answer;
    while (!steady_flow && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    letter_i    <= letter;
    left_pos_i  <= left;
    right_pos_i <= right;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    apply_item(cmd, letter, left, right, has_answer, answer);
    if (has_answer) expected_answers.insert(expected_answers.size(), typed ? want : answer);
    items_sent++;
  endtask

  task automatic send_valid_query();
    int unsigned l;
    int unsigned r;
    if (text_len == 0) begin
      send_item(rlsq_pkg::CMD_QUERY, rand_letter(), posn(1), posn(1));
    end else begin
      l = $urandom_range(1, text_len);
      r = ($urandom_range(0, 9) == 0) ? l : $urandom_range(l, text_len);
      send_item(rlsq_pkg::CMD_QUERY, rand_letter(), posn(l), posn(r));
    end
  endtask

  task automatic send_broken_query();
    int unsigned l;
    case ($urandom_range(0, 3))
      0: send_item(rlsq_pkg::CMD_QUERY, rand_letter(), posn(0),
                   posn($urandom_range(0, text_len)));
      1: begin
        l = $urandom_range(2, 40);
        send_item(rlsq_pkg::CMD_QUERY, rand_letter(), posn(l), posn($urandom_range(1, l - 1)));
      end
      2: send_item(rlsq_pkg::CMD_QUERY, rand_letter(), posn(1),
                   posn(text_len + $urandom_range(1, 4)));
      default: send_item(rlsq_pkg::CMD_QUERY, rand_letter(), rand_posn(), rand_posn());
    endcase
  endtask

  task automatic build_short_string();
    int span;
    int base;
    int pick;
    if ($urandom_range(0, 3) != 0)
      send_item(rlsq_pkg::CMD_CLEAR, rand_letter(), rand_posn(), rand_posn());
    pick = $urandom_range(0, 9);
    span = (pick < 3) ? 1 : (pick < 6) ? 2 : (pick < 8) ? 3 : ALPHABET;
    base = $urandom_range(0, ALPHABET - span);
    repeat ($urandom_range(1, 40)) begin
      send_item(rlsq_pkg::CMD_APPEND, ltr(base + $urandom_range(0, span - 1)),
                rand_posn(), rand_posn());
      if ($urandom_range(0, 99) < 30) send_valid_query();
    end
    repeat ($urandom_range(2, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) send_valid_query();
      else if (pick < 88) send_broken_query();
      else send_item(rlsq_pkg::CMD_W'($urandom_range(0, 3)), rand_letter(), rand_posn(),
                     rand_posn());
    end
  endtask

  task automatic fill_to_capacity();
    send_item(rlsq_pkg::CMD_CLEAR, ltr(0), posn(0), posn(0));
    for (int p = 0; p < MAX_LEN; p++) begin
      send_item(rlsq_pkg::CMD_APPEND,
                ltr((p < MAX_LEN / 2) ? $urandom_range(0, 1) : $urandom_range(0, ALPHABET - 1)),
                rand_posn(), rand_posn());
      if ($urandom_range(0, 99) < 5) send_valid_query();
    end
    send_item(rlsq_pkg::CMD_APPEND, ltr(0), posn(0), posn(0));
    send_item(rlsq_pkg::CMD_APPEND, ltr(ALPHABET - 1), posn(0), posn(0));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(1), posn(MAX_LEN));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(MAX_LEN), posn(MAX_LEN));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(1), posn(MAX_LEN - 1));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(MAX_LEN / 2), posn(MAX_LEN));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(1), posn(MAX_LEN + 1));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(MAX_LEN + 1), posn(MAX_LEN + 1));
    send_item(rlsq_pkg::CMD_QUERY, ltr(0), posn(MAX_LEN), posn(1));
    repeat (20) send_valid_query();
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (answer_yes_o !== oldest_answer.yes) begin
          $error("answer_yes: expected %0d, got %0d", oldest_answer.yes, answer_yes_o);
          error_count++;
        end
        if (distinct_letters_o !== oldest_answer.letters) begin
          $error("distinct_letters: expected %0d, got %0d", oldest_answer.letters,
                 distinct_letters_o);
          error_count++;
        end
        if (range_error_o !== oldest_answer.err) begin
          $error("range_error: expected %0d, got %0d", oldest_answer.err, range_error_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed[i].cmd, directed[i].letter, directed[i].left, directed[i].right,
                directed[i].typed, directed[i].want);
    end
    while (items_sent < 400) build_short_string();
    steady_flow <= 1'b1;
    while (items_sent < 600) build_short_string();
    steady_flow <= 1'b0;
    fill_to_capacity();
    while (items_sent < 1800) build_short_string();
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
